// ===== hdl/fpc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpc_pkg: shared types and constants for the frustum plane cull block
// Item codes, fixed field widths, parameter defaults and the item record
// that travels along the plane cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

  // item kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_POINT  = 2'd1;
  localparam logic [1:0] KIND_CORNER = 2'd2;

  // fixed field widths
  localparam int KIND_W   = 2;
  localparam int IDX_W    = 3;
  localparam int COORD_W  = 32;
  localparam int MARGIN_W = 16;
  localparam int PROD_W   = 2 * COORD_W;
  // three products, shifted intercept and margin, with headroom
  localparam int SUM_W    = PROD_W + 2;
  // box corner counter, wide enough for up to eight corners
  localparam int CNT_W    = 3;

  // parameter defaults
  localparam int PLANE_COUNT_DEF = 6;
  localparam int BOX_CORNERS_DEF = 8;

  // margin after reset, about 0.01 in Q16.16
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd655;

  // one input item as it moves down the chain
  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [IDX_W-1:0]          plane_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic signed [COORD_W-1:0] plane_offset;
  } fpc_item_t;

endpackage

`default_nettype wire

// ===== hdl/fpc_channels.sv =====
// ----------------------------------------------------------------------------
// fpc_channels: valid/ready channels of the frustum plane cull block
// Input item channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [fpc_pkg::KIND_W-1:0]           kind;
  logic [fpc_pkg::IDX_W-1:0]            plane_index;
  logic signed [fpc_pkg::COORD_W-1:0]   coord_x;
  logic signed [fpc_pkg::COORD_W-1:0]   coord_y;
  logic signed [fpc_pkg::COORD_W-1:0]   coord_z;
  logic signed [fpc_pkg::COORD_W-1:0]   plane_offset;

  modport source (
    output valid, kind, plane_index, coord_x, coord_y, coord_z, plane_offset,
    input  ready
  );
  modport sink (
    input  valid, kind, plane_index, coord_x, coord_y, coord_z, plane_offset,
    output ready
  );
endinterface

interface fpc_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic from_box;

  modport source (output valid, inside_res, from_box, input ready);
  modport sink   (input  valid, inside_res, from_box, output ready);
endinterface

`default_nettype wire

// ===== hdl/frustum_plane_cull.sv =====
// ----------------------------------------------------------------------------
// frustum_plane_cull: six-plane view frustum culling in Q16.16
// Chain of plane cells followed by box tracking and a result register.
// ----------------------------------------------------------------------------
// Takes one item per cycle and delivers one result per cycle when the result
// side keeps up. Each item walks a chain of PLANE_COUNT plane cells, two
// stages per cell (a multiply stage with three 32x32 multipliers and a
// sum-and-compare stage), then the result register, 2*PLANE_COUNT+1
// registers in all. A stalled result holds the chain back only once every
// stage behind it is full.
// Plane loads travel down the same chain and update a cell as they pass it,
// so every item sees exactly the planes loaded before it. Every plane must
// be loaded before the first point or box test. Write behind_margin only
// while no items are in flight.
`default_nettype none

module frustum_plane_cull #(
  parameter int PLANE_COUNT = fpc_pkg::PLANE_COUNT_DEF,
  parameter int BOX_CORNERS = fpc_pkg::BOX_CORNERS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  fpc_in_if.sink                             items,
  fpc_out_if.source                          results,
  input  wire logic                          cfg_wr_en,
  input  wire logic [fpc_pkg::MARGIN_W-1:0]  cfg_wr_data
);

  logic [fpc_pkg::MARGIN_W-1:0] behind_margin;

  logic                   link_valid  [PLANE_COUNT+1];
  logic                   link_ready  [PLANE_COUNT+1];
  fpc_pkg::fpc_item_t     link_item   [PLANE_COUNT+1];
  logic [PLANE_COUNT-1:0] link_behind [PLANE_COUNT+1];

  // margin register
  always_ff @(posedge clk) begin
    if (rst) begin
      behind_margin <= fpc_pkg::MARGIN_RESET;
    end else if (cfg_wr_en) begin
      behind_margin <= cfg_wr_data;
    end
  end

  // head of the chain
  assign link_valid[0]              = items.valid;
  assign items.ready                = link_ready[0];
  assign link_item[0].kind          = items.kind;
  assign link_item[0].plane_index   = items.plane_index;
  assign link_item[0].coord_x       = items.coord_x;
  assign link_item[0].coord_y       = items.coord_y;
  assign link_item[0].coord_z       = items.coord_z;
  assign link_item[0].plane_offset  = items.plane_offset;
  assign link_behind[0]             = '0;

  // plane cells
  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
    fpc_cell #(
      .PLANE_COUNT (PLANE_COUNT),
      .CELL_ID     (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .margin    (behind_margin),
      .up_valid  (link_valid[i]),
      .up_ready  (link_ready[i]),
      .up_item   (link_item[i]),
      .up_behind (link_behind[i]),
      .dn_valid  (link_valid[i+1]),
      .dn_ready  (link_ready[i+1]),
      .dn_item   (link_item[i+1]),
      .dn_behind (link_behind[i+1])
    );
  end

  // box tracking and results
  fpc_box #(
    .PLANE_COUNT (PLANE_COUNT),
    .BOX_CORNERS (BOX_CORNERS)
  ) u_box (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (link_valid[PLANE_COUNT]),
    .up_ready  (link_ready[PLANE_COUNT]),
    .up_kind   (link_item[PLANE_COUNT].kind),
    .up_behind (link_behind[PLANE_COUNT]),
    .results   (results)
  );

  // a new result only follows a point or corner transfer out of the chain
  a_result_source : assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |->
      $past(link_valid[PLANE_COUNT] && link_ready[PLANE_COUNT] &&
            (link_item[PLANE_COUNT].kind == fpc_pkg::KIND_POINT ||
             link_item[PLANE_COUNT].kind == fpc_pkg::KIND_CORNER)))
    else $error("result appeared without a test leaving the chain");

  // a plane load leaving the chain never produces a result
  a_load_silent : assert property (@(posedge clk) disable iff (rst)
    (link_valid[PLANE_COUNT] && link_ready[PLANE_COUNT] &&
     link_item[PLANE_COUNT].kind == fpc_pkg::KIND_LOAD) |=> !$rose(results.valid))
    else $error("plane load produced a result");

  // margin comes out of reset at its default
  a_margin_reset : assert property (@(posedge clk)
    $past(rst) |-> behind_margin == fpc_pkg::MARGIN_RESET)
    else $error("margin not at its reset value");

endmodule

`default_nettype wire

// ===== hdl/fpc_cell.sv =====
// ----------------------------------------------------------------------------
// fpc_cell: one plane of the culling chain
// Holds one plane, multiplies the passing point by its normal in the first
// stage and sums and compares in the second. A load for this plane is taken
// as it enters, so later items see the new plane and earlier ones do not.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_cell #(
  parameter int PLANE_COUNT = fpc_pkg::PLANE_COUNT_DEF,
  parameter int CELL_ID     = 0
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [fpc_pkg::MARGIN_W-1:0]     margin,
  input  wire logic                             up_valid,
  output logic                                  up_ready,
  input  wire fpc_pkg::fpc_item_t               up_item,
  input  wire logic [PLANE_COUNT-1:0]           up_behind,
  output logic                                  dn_valid,
  input  wire logic                             dn_ready,
  output fpc_pkg::fpc_item_t                    dn_item,
  output logic [PLANE_COUNT-1:0]                dn_behind
);

  // plane held by this cell
  logic signed [fpc_pkg::COORD_W-1:0] norm_x;
  logic signed [fpc_pkg::COORD_W-1:0] norm_y;
  logic signed [fpc_pkg::COORD_W-1:0] norm_z;
  logic signed [fpc_pkg::COORD_W-1:0] norm_off;

  // product stage
  logic                               a_valid;
  fpc_pkg::fpc_item_t                 a_item;
  logic [PLANE_COUNT-1:0]             a_behind;
  logic signed [fpc_pkg::PROD_W-1:0]  a_px;
  logic signed [fpc_pkg::PROD_W-1:0]  a_py;
  logic signed [fpc_pkg::PROD_W-1:0]  a_pz;
  logic signed [fpc_pkg::COORD_W-1:0] a_off;

  // sum stage
  logic                               b_valid;
  fpc_pkg::fpc_item_t                 b_item;
  logic [PLANE_COUNT-1:0]             b_behind;

  logic                               a_take;
  logic                               b_take;
  logic                               load_hit;
  logic signed [fpc_pkg::PROD_W-1:0]  mul_x;
  logic signed [fpc_pkg::PROD_W-1:0]  mul_y;
  logic signed [fpc_pkg::PROD_W-1:0]  mul_z;
  logic signed [fpc_pkg::SUM_W-1:0]   plane_dist;
  logic                               behind_now;

  // stage handshakes, a bubble lets the stage fill while the next one stalls
  assign b_take   = !b_valid || dn_ready;
  assign a_take   = !a_valid || b_take;
  assign up_ready = a_take;

  assign load_hit = up_valid && a_take && (up_item.kind == fpc_pkg::KIND_LOAD)
                    && (up_item.plane_index == fpc_pkg::IDX_W'(CELL_ID));

  // normal times point, one multiplier per axis
  assign mul_x = $signed(up_item.coord_x) * $signed(norm_x);
  assign mul_y = $signed(up_item.coord_y) * $signed(norm_y);
  assign mul_z = $signed(up_item.coord_z) * $signed(norm_z);

  // exact signed distance plus margin, Q32.32
  assign plane_dist = $signed({{2{a_px[fpc_pkg::PROD_W-1]}}, a_px})
                    + $signed({{2{a_py[fpc_pkg::PROD_W-1]}}, a_py})
                    + $signed({{2{a_pz[fpc_pkg::PROD_W-1]}}, a_pz})
                    + $signed({{18{a_off[fpc_pkg::COORD_W-1]}}, a_off, 16'b0})
                    + $signed({34'b0, margin, 16'b0});
  assign behind_now = plane_dist[fpc_pkg::SUM_W-1];

  // plane storage
  always_ff @(posedge clk) begin
    if (load_hit) begin
      norm_x   <= up_item.coord_x;
      norm_y   <= up_item.coord_y;
      norm_z   <= up_item.coord_z;
      norm_off <= up_item.plane_offset;
    end
  end

  // product stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_take) begin
      a_valid <= up_valid;
    end
    if (a_take && up_valid) begin
      a_item   <= up_item;
      a_behind <= up_behind;
      a_px     <= mul_x;
      a_py     <= mul_y;
      a_pz     <= mul_z;
      a_off    <= norm_off;
    end
  end

  // sum stage registers, this cell adds its own behind flag
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_take) begin
      b_valid <= a_valid;
    end
    if (b_take && a_valid) begin
      b_item   <= a_item;
      b_behind <= a_behind | (PLANE_COUNT'(behind_now) << CELL_ID);
    end
  end

  assign dn_valid  = b_valid;
  assign dn_item   = b_item;
  assign dn_behind = b_behind;

endmodule

`default_nettype wire

// ===== hdl/fpc_box.sv =====
// ----------------------------------------------------------------------------
// fpc_box: box tracking and result register
// Gathers per-plane behind flags over the corners of a box, and turns point
// and finished box tests into results held in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_box #(
  parameter int PLANE_COUNT = fpc_pkg::PLANE_COUNT_DEF,
  parameter int BOX_CORNERS = fpc_pkg::BOX_CORNERS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        up_valid,
  output logic                             up_ready,
  input  wire logic [fpc_pkg::KIND_W-1:0]  up_kind,
  input  wire logic [PLANE_COUNT-1:0]      up_behind,
  fpc_out_if.source                        results
);

  logic [PLANE_COUNT-1:0]       mask;
  logic [fpc_pkg::CNT_W-1:0]    count;
  logic                         res_valid;
  logic                         res_inside;
  logic                         res_from_box;

  logic                         is_point;
  logic                         is_corner;
  logic                         last_corner;
  logic                         emits;
  logic                         fire;
  logic [PLANE_COUNT-1:0]       mask_after;

  // decode the arriving item
  assign is_point    = (up_kind == fpc_pkg::KIND_POINT);
  assign is_corner   = (up_kind == fpc_pkg::KIND_CORNER);
  assign last_corner = (count == fpc_pkg::CNT_W'(BOX_CORNERS - 1));
  assign emits       = is_point || (is_corner && last_corner);
  assign mask_after  = mask & up_behind;

  // items with no result always pass, others need room in the result register
  assign up_ready = !emits || !res_valid || results.ready;
  assign fire     = up_valid && up_ready;

  // box progress
  always_ff @(posedge clk) begin
    if (rst) begin
      mask  <= {PLANE_COUNT{1'b1}};
      count <= '0;
    end else if (fire && is_corner) begin
      if (last_corner) begin
        mask  <= {PLANE_COUNT{1'b1}};
        count <= '0;
      end else begin
        mask  <= mask_after;
        count <= count + fpc_pkg::CNT_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire && emits) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
    if (fire && emits) begin
      res_inside   <= is_point ? ~|up_behind : ~|mask_after;
      res_from_box <= is_corner;
    end
  end

  assign results.valid      = res_valid;
  assign results.inside_res = res_inside;
  assign results.from_box   = res_from_box;

endmodule

`default_nettype wire
